### rtl/plal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plal_pkg
// Shared types and constants for the piecewise-linear area lookup.
// ----------------------------------------------------------------------------
package plal_pkg;

  localparam int LevelW = 32;
  localparam int AreaW  = 32;
  localparam int PcW    = 5;
  localparam int AddrW  = 3;

  localparam logic [AddrW-1:0] ADDR_POINT_COUNT = 3'd0;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REG_BELOW  = 2'd0;
  localparam logic [1:0] REG_INTERP = 2'd1;
  localparam logic [1:0] REG_BEYOND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } plal_state_t;

  // Query token that walks the cell row
  typedef struct packed {
    logic                     valid;
    logic                     found;
    logic [1:0]               region;
    logic signed [LevelW-1:0] query;
    logic signed [LevelW-1:0] lo;
    logic signed [LevelW-1:0] hi;
    logic [AreaW-1:0]         a0;
    logic [AreaW-1:0]         a1;
    logic [AreaW-1:0]         last_area;
    logic signed [LevelW-1:0] prev_level;
    logic [AreaW-1:0]         prev_area;
  } plal_tok_t;

endpackage

### rtl/plal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plal_in_if / plal_out_if
// Valid/ready channels for load/query items and for result items.
// ----------------------------------------------------------------------------
interface plal_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_level;
  logic [31:0]        entry_area;
  logic signed [31:0] query_level;

  modport source (output valid, func, entry_index, entry_level, entry_area, query_level,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_level, entry_area, query_level,
                  output ready);
endinterface

interface plal_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_area;
  logic [1:0]  region;

  modport source (output valid, top_area, region, input ready);
  modport sink   (input valid, top_area, region, output ready);
endinterface

### rtl/plal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plal_cell
// One breakpoint: holds a level/area pair and tests the passing query token.
// ----------------------------------------------------------------------------
module plal_cell import plal_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int IDX        = 0,
  localparam int NW        = $clog2(MAX_POINTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic signed [LevelW-1:0] wr_level,
  input  logic [AreaW-1:0]         wr_area,
  input  logic [NW-1:0]            used,
  input  plal_tok_t                tok_in,
  output plal_tok_t                tok_out_r
);

  logic signed [LevelW-1:0] level_r;
  logic [AreaW-1:0]         area_r;
  plal_tok_t                tok_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_r <= wr_level;
      area_r  <= wr_area;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found) begin
      if (IDX == 0) begin
        if (tok_in.query <= level_r) begin
          tok_nxt.found  = 1'b1;
          tok_nxt.region = REG_BELOW;
          tok_nxt.a0     = area_r;
        end
      end else if ((NW'(IDX) < used) && (tok_in.query < level_r)) begin
        tok_nxt.found  = 1'b1;
        tok_nxt.region = REG_INTERP;
        tok_nxt.lo     = tok_in.prev_level;
        tok_nxt.a0     = tok_in.prev_area;
        tok_nxt.hi     = level_r;
        tok_nxt.a1     = area_r;
      end
    end
    if (NW'(IDX + 1) == used) begin
      tok_nxt.last_area = area_r;
    end
    tok_nxt.prev_level = level_r;
    tok_nxt.prev_area  = area_r;
  end

  // only the valid bit is cleared by reset; the payload just follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_out_r.valid <= 1'b0;
    end else begin
      tok_out_r <= tok_nxt;
    end
  end

endmodule

### rtl/plal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plal_div
// Restoring divider, one quotient bit per cycle; quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module plal_div import plal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done_r,
  output logic [31:0] quo_r,
  output logic        rem_nz
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] low_r;
  logic [31:0] den_r;
  logic [32:0] rem_sh;
  logic        take;

  assign rem_sh = {rem_r, low_r[31]};
  assign take   = rem_sh >= {1'b0, den_r};
  assign rem_nz = rem_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[63:32];
      low_r <= num[31:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= take ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], take};
    end
  end

endmodule

### rtl/piecewise_linear_area_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_area_lookup_top
// Breakpoint table of level/area pairs with linear interpolation between them.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only in the idle state. A query
// walks the row of MAX_POINTS breakpoint cells one cell per cycle. When it
// interpolates, the multiply, the divider start, the bit-serial divider, taking
// the quotient and the output register load follow in that order; at or beyond
// the ends it goes straight from the row to the output register load. A full
// output register holds the sequencer until the receiver takes the result. A
// finished result sits in the output register, so the next item may be
// accepted before it is taken.
module piecewise_linear_area_lookup_top import plal_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  plal_in_if.sink          in_ch,
  plal_out_if.source       out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NW = $clog2(MAX_POINTS + 1);

  plal_state_t   state_r, state_nxt;
  logic [PcW-1:0] point_count_r;
  logic [NW-1:0]  used;
  logic           in_acc, load, query;
  plal_tok_t      head;
  plal_tok_t      tok [MAX_POINTS];
  plal_tok_t      tail;
  logic [MAX_POINTS-1:0] tok_valid;

  logic [AreaW-1:0] a0_r;
  logic [31:0]      diff_r, num_r, span_r;
  logic             fall_r;
  logic [63:0]      prod_r;
  logic [AreaW-1:0] res_r;
  logic [1:0]       region_r;

  logic             div_start, div_done, div_rem_nz;
  logic [31:0]      div_quo;

  logic             out_valid_r;
  logic [AreaW-1:0] out_area_r;
  logic [1:0]       out_region_r;
  logic             out_load;

  // Configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_POINT_COUNT) ? {27'd0, point_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PcW'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_POINT_COUNT) begin
      point_count_r <= cfg_pwdata[PcW-1:0];
    end
  end

  always_comb begin
    if (point_count_r == '0) begin
      used = NW'(1);
    end else if (32'(point_count_r) > MAX_POINTS) begin
      used = NW'(MAX_POINTS);
    end else begin
      used = NW'(point_count_r);
    end
  end

  // Input side
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load        = in_acc && (in_ch.func == FUNC_LOAD);
  assign query       = in_acc && (in_ch.func == FUNC_QUERY);

  always_comb begin
    head            = '0;
    head.valid      = query;
    head.query      = in_ch.query_level;
  end

  // Cell row
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    plal_tok_t tin;
    logic      wen;
    assign tin = (i == 0) ? head : tok[(i == 0) ? 0 : i - 1];
    assign wen = load && ({28'd0, in_ch.entry_index} == 32'(i));
    assign tok_valid[i] = tok[i].valid;

    plal_cell #(.MAX_POINTS(MAX_POINTS), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wen),
      .wr_level  (in_ch.entry_level),
      .wr_area   (in_ch.entry_area),
      .used      (used),
      .tok_in    (tin),
      .tok_out_r (tok[i])
    );
  end

  assign tail = tok[MAX_POINTS-1];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (query) state_nxt = ST_SCAN;
      ST_SCAN:   if (tail.valid) begin
        state_nxt = (tail.found && tail.region == REG_INTERP) ? ST_MUL : ST_DONE;
      end
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_DSTART: div_start = 1'b1;
      ST_DONE:   out_load  = !out_valid_r || out_ch.ready;
      default: begin
        div_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && tail.valid) begin
      a0_r   <= tail.a0;
      fall_r <= tail.a1 < tail.a0;
      diff_r <= (tail.a1 < tail.a0) ? tail.a0 - tail.a1 : tail.a1 - tail.a0;
      num_r  <= 32'(tail.query - tail.lo);
      span_r <= 32'(tail.hi - tail.lo);
      if (tail.found) begin
        res_r    <= tail.a0;
        region_r <= tail.region;
      end else begin
        res_r    <= tail.last_area;
        region_r <= REG_BEYOND;
      end
    end else if (state_r == ST_MUL) begin
      prod_r <= 64'(diff_r) * 64'(num_r);
    end else if (state_r == ST_DIV && div_done) begin
      // round down in both directions
      res_r <= fall_r ? a0_r - div_quo - 32'(div_rem_nz) : a0_r + div_quo;
    end
  end

  plal_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (prod_r),
    .den    (span_r),
    .done_r (div_done),
    .quo_r  (div_quo),
    .rem_nz (div_rem_nz)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_area_r   <= res_r;
      out_region_r <= region_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.top_area = out_area_r;
  assign out_ch.region   = out_region_r;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one query in the cell row");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.region == REG_BELOW || out_ch.region == REG_INTERP ||
                      out_ch.region == REG_BEYOND))
    else $error("bad region code on result");
`endif

endmodule

### verif/piecewise_linear_area_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_area_lookup_checker
// Watches the item channels and the register port. Tracks the breakpoint
// table, predicts each lookup area and region, and compares them in order.
// ----------------------------------------------------------------------------
module piecewise_linear_area_lookup_checker import plal_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  plal_in_if               in_ch,
  plal_out_if              out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic             cfg_pready,
  input  logic [AddrW-1:0] cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output int               fail_count
);

  typedef struct packed {
    logic [AreaW-1:0] top_area;
    logic [1:0]       region;
  } area_result_t;

  logic signed [LevelW-1:0] level_tbl [MAX_POINTS];
  logic [AreaW-1:0]         area_tbl  [MAX_POINTS];
  logic [PcW-1:0]           point_count;
  area_result_t             pending_areas[$];

  function automatic area_result_t lookup_area(input logic signed [LevelW-1:0] q);
    area_result_t r;
    int unsigned n;
    longint lo, hi, y;
    logic [63:0] span, num, p, quo;
    logic [AreaW-1:0] a0, a1;
    n = point_count;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    y = q;
    if (y <= longint'(level_tbl[0])) begin
      r.top_area = area_tbl[0];
      r.region   = REG_BELOW;
      return r;
    end
    for (int i = 1; i < n; i++) begin
      hi = level_tbl[i];
      if (y < hi) begin
        lo   = level_tbl[i-1];
        span = hi - lo;
        num  = y - lo;
        a0   = area_tbl[i-1];
        a1   = area_tbl[i];
        if (a1 >= a0) begin
          p = 64'(a1 - a0) * num;
          r.top_area = a0 + 32'(p / span);
        end else begin
          // falling areas: round the drop up so the result still rounds down
          p   = 64'(a0 - a1) * num;
          quo = p / span + ((p % span) != 0 ? 64'd1 : 64'd0);
          r.top_area = a0 - 32'(quo);
        end
        r.region = REG_INTERP;
        return r;
      end
    end
    r.top_area = area_tbl[n-1];
    r.region   = REG_BEYOND;
    return r;
  endfunction

  always @(posedge clk) begin
    area_result_t exp_r;
    if (!rst_n) begin
      point_count <= 5'd1;
      pending_areas.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_POINT_COUNT)
        point_count <= cfg_pwdata[PcW-1:0];
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_LOAD) begin
          level_tbl[in_ch.entry_index] = in_ch.entry_level;
          area_tbl[in_ch.entry_index]  = in_ch.entry_area;
        end else begin
          pending_areas.push_back(lookup_area(in_ch.query_level));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_areas.size() == 0) begin
          $display("%0t: unexpected result area=%h region=%0d", $time,
                   out_ch.top_area, out_ch.region);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = pending_areas.pop_front();
          if (exp_r.top_area !== out_ch.top_area || exp_r.region !== out_ch.region) begin
            $display("%0t: mismatch expected area=%h region=%0d actual area=%h region=%0d",
                     $time, exp_r.top_area, exp_r.region, out_ch.top_area, out_ch.region);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/piecewise_linear_area_lookup_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_area_lookup_top_tb
// Loads breakpoint tables, sweeps point counts and streams level lookups
// under several idle and stall mixes; the checker scores every result.
// ----------------------------------------------------------------------------
module piecewise_linear_area_lookup_top_tb;
  import plal_pkg::*;

  localparam int MAX_POINTS = 16;
  localparam int DRAIN_WAIT = MAX_POINTS + 48;
  localparam int STUCK_LIMIT = 20000;
  localparam int NUM_PHASES = 16;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;
  int               fail_count;
  int               send_idle_pct = 0, recv_stall_pct = 0;
  int               queries_sent = 0, results_taken = 0, stuck_cycles = 0;
  longint           span_lo, span_hi, span_step;

  plal_in_if  in_ch();
  plal_out_if out_ch();

  piecewise_linear_area_lookup_top #(.MAX_POINTS(MAX_POINTS)) i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  piecewise_linear_area_lookup_checker #(.MAX_POINTS(MAX_POINTS)) i_checker (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready,
    .cfg_paddr, .cfg_pwdata, .fail_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_level = '0;
    in_ch.entry_area = '0;
    in_ch.query_level = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready && in_ch.func == FUNC_QUERY)
        queries_sent <= queries_sent + 1;
      if (out_ch.valid && out_ch.ready)
        results_taken <= results_taken + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input logic func, input logic [3:0] idx,
                           input logic [31:0] lvl, input logic [31:0] area,
                           input logic [31:0] qlvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.entry_index <= idx;
    in_ch.entry_level <= lvl;
    in_ch.entry_area  <= area;
    in_ch.query_level <= qlvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic load_entry(input logic [3:0] idx, input logic [31:0] lvl,
                            input logic [31:0] area);
    send_item(FUNC_LOAD, idx, lvl, area, $urandom);
  endtask

  task automatic query_level(input logic [31:0] qlvl);
    send_item(FUNC_QUERY, 4'($urandom), $urandom, $urandom, qlvl);
  endtask

  // hold the sender until every pending lookup has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (queries_sent != results_taken) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [31:0] value);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_POINT_COUNT;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // fill all entries: mostly a sorted ramp, sometimes random levels and areas
  task automatic load_table();
    longint base;
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < MAX_POINTS; i++) load_entry(4'(i), $urandom, $urandom);
      span_lo = -64'sd2147483648;
      span_hi = 64'sd2147483647;
      span_step = 64'sd65536;
    end else begin
      span_step = ($urandom_range(1) != 0) ? $urandom_range(1, 64) : $urandom_range(1, 1 << 27);
      base = longint'($urandom_range(32'hFFFFFFFF - 32'(15 * span_step))) - 64'sd2147483648;
      span_lo = base;
      span_hi = base + 15 * span_step;
      for (int i = 0; i < MAX_POINTS; i++)
        load_entry(4'(i), 32'(base + i * span_step), $urandom);
    end
  endtask

  function automatic logic [31:0] pick_level();
    longint v;
    if ($urandom_range(9) == 0) return $urandom;
    v = span_lo - span_step + longint'($urandom_range(32'(17 * span_step)));
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return 32'(v);
  endfunction

  initial begin
    logic [31:0] counts[6] = '{32'd16, 32'd0, 32'd31, 32'd17, 32'd2, 32'd15};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes at the ends of a sorted table, single point in use after reset
    load_entry(4'd0, 32'h8000_0000, 32'h0000_0000);
    for (int i = 1; i < MAX_POINTS - 1; i++)
      load_entry(4'(i), 32'(i * 32'h1000_0000 - 32'h7000_0000), 32'hFFFF_FFFF - 32'(i));
    load_entry(4'(MAX_POINTS - 1), 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    query_level(32'h8000_0000);
    query_level(32'h0000_0000);
    query_level(32'h7FFF_FFFF);
    write_point_count(32'd16);
    query_level(32'h8000_0000);
    query_level(32'h8000_0001);
    query_level(32'h9000_0000);
    query_level(32'h0000_0000);
    query_level(32'h7FFF_FFFE);
    query_level(32'h7FFF_FFFF);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_point_count(ph < 6 ? counts[ph] : 32'($urandom_range(31)));
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 47 : 25) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 47 : 25) : 0;
      load_table();
      for (int k = 0; k < 93; k++) begin
        if (ph == 5 && k == 40) drain();
        if ($urandom_range(19) == 0)
          load_entry(4'($urandom), pick_level(), $urandom);
        else
          query_level(pick_level());
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/plal_pkg.sv
rtl/plal_if.sv
rtl/plal_cell.sv
rtl/plal_div.sv
rtl/piecewise_linear_area_lookup_top.sv
verif/piecewise_linear_area_lookup_checker.sv
verif/piecewise_linear_area_lookup_top_tb.sv
